### hdl/rv64alu_pkg.sv
// Shared types and constants for the RV64 integer ALU subset execute block.
`timescale 1ns / 1ps

package rv64alu_pkg;

  // Fixed field widths of the item ports.
  localparam int INSTR_W   = 32;
  localparam int DATA_W    = 64;
  localparam int REG_IDX_W = 5;
  localparam int REG_COUNT = 32;
  localparam int IMM_W     = 12;

  // Default register width.
  localparam int XLEN_DEFAULT = 64;

  typedef logic [6:0]           opcode_t;
  typedef logic [2:0]           func3_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;

  // Opcodes that the block executes.
  localparam opcode_t OPC_REG = 7'b0110011;
  localparam opcode_t OPC_IMM = 7'b0010011;

  // func3 code that selects the add on register arithmetic.
  localparam func3_t FUNC3_ADD = 3'b000;

  // Register that always reads as zero.
  localparam reg_idx_t REG_ZERO = '0;

endpackage

### hdl/rv64_alu_subset_execute.sv
// Top level of the RV64 integer ALU subset execute block.
`timescale 1ns / 1ps

// The block takes one RISC-V instruction word per item and returns one result
// per item: the destination index, the value that register holds after the
// instruction, and whether a write happened or the opcode was unknown. It
// accepts one item every clock cycle unless the output stalls. The register
// file read is registered on acceptance into the execute stage, and the ALU
// result is then registered in the output register. A result that depends on the item just
// ahead is taken from a bypass register, so back-to-back dependent items run
// at full rate. The 32 registers live in a two-read-port memory; a per-entry
// valid bit, cleared by reset, makes an unwritten register read as zero, so
// no clearing pass is needed after reset.
module rv64_alu_subset_execute #(
  parameter int XLEN = rv64alu_pkg::XLEN_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rv64alu_pkg::INSTR_W-1:0]   instruction,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rv64alu_pkg::REG_IDX_W-1:0] dest_index,
  output logic [rv64alu_pkg::DATA_W-1:0]    dest_value,
  output logic                              wrote,
  output logic                              unknown_op
);

  import rv64alu_pkg::*;

  // Register file storage and its valid bits.
  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] reg_valid;

  // Execute stage registers.
  logic               s1_valid;
  logic [INSTR_W-1:0] s1_instr;
  logic [XLEN-1:0]    rdata_a;
  logic [XLEN-1:0]    rdata_b;
  logic               vld_a;
  logic               vld_b;
  logic               byp_a;
  logic               byp_b;
  logic [XLEN-1:0]    wb_value;

  // Handshake and decode signals.
  logic     accept;
  logic     s1_advance;
  logic     s1_write;
  opcode_t  in_opcode;
  logic     in_known;
  reg_idx_t addr_a;
  reg_idx_t addr_b;

  opcode_t         s1_opcode;
  func3_t          s1_func3;
  reg_idx_t        s1_rd;
  logic [IMM_W-1:0] s1_imm;
  logic            s1_is_reg;
  logic            s1_is_imm;
  logic [XLEN-1:0] op_a;
  logic [XLEN-1:0] op_b;
  logic [XLEN-1:0] imm_ext;
  logic [XLEN-1:0] alu_result;
  logic [XLEN-1:0] s1_value;

  // The stage moves on when the output register is free or being emptied.
  assign s1_advance = s1_valid && (!out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign accept     = in_valid && !in_stall;

  // Read addresses: an unknown opcode reads its destination on port A.
  assign in_opcode = instruction[6:0];
  assign in_known  = (in_opcode == OPC_REG) || (in_opcode == OPC_IMM);
  assign addr_a    = in_known ? instruction[19:15] : instruction[11:7];
  assign addr_b    = instruction[24:20];

  // Fields of the item in the execute stage.
  assign s1_opcode = s1_instr[6:0];
  assign s1_rd     = s1_instr[11:7];
  assign s1_func3  = s1_instr[14:12];
  assign s1_imm    = s1_instr[31:20];
  assign s1_is_reg = (s1_opcode == OPC_REG);
  assign s1_is_imm = (s1_opcode == OPC_IMM);

  // Operands come from the bypass when the item ahead wrote the same register.
  assign op_a    = byp_a ? wb_value : (vld_a ? rdata_a : '0);
  assign op_b    = byp_b ? wb_value : (vld_b ? rdata_b : '0);
  assign imm_ext = {{(XLEN-IMM_W){s1_imm[IMM_W-1]}}, s1_imm};

  // ALU: add, and, or add immediate.
  always_comb begin
    if (s1_is_reg) begin
      alu_result = (s1_func3 == FUNC3_ADD) ? (op_a + op_b) : (op_a & op_b);
    end else begin
      alu_result = op_a + imm_ext;
    end
  end

  // Value reported for the destination; x0 always reads as zero.
  always_comb begin
    if (s1_rd == REG_ZERO) begin
      s1_value = '0;
    end else if (s1_is_reg || s1_is_imm) begin
      s1_value = alu_result;
    end else begin
      s1_value = op_a;
    end
  end

  // A write to x0 is dropped, so x0 keeps reading as zero.
  assign s1_write = s1_advance && (s1_is_reg || s1_is_imm) && (s1_rd != REG_ZERO);

  // Execute stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Execute stage payload: instruction, registered reads and bypass flags.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_instr <= instruction;
      rdata_a  <= mem[addr_a];
      rdata_b  <= mem[addr_b];
      vld_a    <= reg_valid[addr_a];
      vld_b    <= reg_valid[addr_b];
      byp_a    <= s1_write && (s1_rd == addr_a);
      byp_b    <= s1_write && (s1_rd == addr_b);
    end
  end

  // Register file write port and the bypass copy of the last written value.
  always_ff @(posedge clk) begin
    if (s1_write) begin
      mem[s1_rd] <= alu_result;
      wb_value   <= alu_result;
    end
  end

  // Valid bits: an entry reads as zero until it has been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      reg_valid <= '0;
    end else if (s1_write) begin
      reg_valid[s1_rd] <= 1'b1;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_advance) begin
      dest_index <= s1_rd;
      dest_value <= DATA_W'(s1_value);
      wrote      <= s1_is_reg || s1_is_imm;
      unknown_op <= !(s1_is_reg || s1_is_imm);
    end
  end

endmodule

### tb/testbench.sv
// Self-checking testbench for the RV64 integer ALU subset execute block.
`timescale 1ns / 1ps

module testbench;
  import rv64alu_pkg::*;

  localparam int XLEN        = XLEN_DEFAULT;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 20;
  localparam int HOLD_CYCLES = 300;

  // func3 codes used in the directed part; on register words any code other than add selects AND.
  localparam func3_t FUNC3_AND = 3'b111;
  localparam func3_t FUNC3_OR  = 3'b110;
  localparam func3_t FUNC3_SLT = 3'b010;

  // Opcodes outside the executed subset.
  localparam opcode_t OPC_LUI    = 7'b0110111;
  localparam opcode_t OPC_BRANCH = 7'b1100011;

  localparam logic [DATA_W-1:0] WORD_MASK =
    (XLEN >= DATA_W) ? {DATA_W{1'b1}} : ((64'd1 << XLEN) - 64'd1);

  typedef struct packed {
    reg_idx_t          rd;
    logic [DATA_W-1:0] value;
    logic              wrote;
    logic              unknown;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [INSTR_W-1:0] instruction = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  reg_idx_t dest_index;
  logic [DATA_W-1:0] dest_value;
  logic wrote;
  logic unknown_op;

  // Architectural register file as the block should see it.
  logic [DATA_W-1:0] arch_regs [REG_COUNT];
  exec_result_t expected_results [$];

  int src_idle_pct = 0;
  int stall_pct = 0;
  logic out_hold = 1'b0;
  int mismatches = 0;
  int checked = 0;
  int cycles = 0;
  int n_reg_ops = 0;
  int n_imm_ops = 0;
  int n_unknown = 0;

  rv64_alu_subset_execute #(.XLEN(XLEN)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .instruction(instruction),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .dest_index (dest_index),
    .dest_value (dest_value),
    .wrote      (wrote),
    .unknown_op (unknown_op)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               expected_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Register arithmetic word.
  function automatic logic [INSTR_W-1:0] enc_reg(reg_idx_t rd, reg_idx_t rs1, reg_idx_t rs2,
                                                 func3_t f3, logic [6:0] f7);
    return {f7, rs2, rs1, f3, rd, OPC_REG};
  endfunction

  // Immediate arithmetic word.
  function automatic logic [INSTR_W-1:0] enc_imm(reg_idx_t rd, reg_idx_t rs1,
                                                 logic [IMM_W-1:0] imm, func3_t f3);
    return {imm, rs1, f3, rd, OPC_IMM};
  endfunction

  // Executes one instruction on the architectural registers and returns the result.
  function automatic exec_result_t execute_instr(logic [INSTR_W-1:0] w);
    opcode_t opc;
    func3_t f3;
    reg_idx_t rd, rs1, rs2;
    logic [DATA_W-1:0] a, b, imm;
    exec_result_t r;
    opc = w[6:0];
    rd  = w[11:7];
    f3  = w[14:12];
    rs1 = w[19:15];
    rs2 = w[24:20];
    a   = arch_regs[rs1];
    b   = arch_regs[rs2];
    imm = {{(DATA_W-IMM_W){w[31]}}, w[31:20]};
    r.wrote = 1'b0;
    r.unknown = 1'b0;
    case (opc)
      OPC_REG: begin
        arch_regs[rd] = ((f3 == FUNC3_ADD) ? a + b : a & b) & WORD_MASK;
        r.wrote = 1'b1;
        n_reg_ops++;
      end
      OPC_IMM: begin
        arch_regs[rd] = (a + imm) & WORD_MASK;
        r.wrote = 1'b1;
        n_imm_ops++;
      end
      default: begin
        r.unknown = 1'b1;
        n_unknown++;
      end
    endcase
    // x0 is cleared again after every instruction.
    arch_regs[REG_ZERO] = '0;
    r.rd = rd;
    r.value = arch_regs[rd];
    return r;
  endfunction

  // Offers one item, waits for it to be taken, then records the expected result.
  task automatic send_instr(logic [INSTR_W-1:0] w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    instruction <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(execute_instr(w));
  endtask

  // Register index biased toward a few registers so that items depend on each other.
  function automatic reg_idx_t rand_reg();
    if ($urandom_range(0, 3) == 0) return reg_idx_t'($urandom_range(0, REG_COUNT - 1));
    return reg_idx_t'($urandom_range(0, 7));
  endfunction

  // Mostly well-formed arithmetic with random content, some raw words.
  function automatic logic [INSTR_W-1:0] rand_instr();
    int pick;
    func3_t f3;
    logic [IMM_W-1:0] imm;
    pick = $urandom_range(0, 99);
    f3 = func3_t'($urandom_range(0, 7));
    if (pick < 45) begin
      if ($urandom_range(0, 1)) f3 = FUNC3_ADD;
      return enc_reg(rand_reg(), rand_reg(), rand_reg(), f3, 7'($urandom));
    end else if (pick < 90) begin
      case ($urandom_range(0, 5))
        0: imm = 12'h7FF;
        1: imm = 12'h800;
        2: imm = 12'hFFF;
        default: imm = 12'($urandom);
      endcase
      return enc_imm(rand_reg(), rand_reg(), imm, f3);
    end
    return $urandom;
  endfunction

  // Extremes of the immediate, wrap-around, both register operations, x0 writes
  // and back-to-back dependent items.
  task automatic test_arith_edges();
    src_idle_pct = 0;
    stall_pct <= 0;
    send_instr(enc_imm(5'd1, REG_ZERO, 12'hFFF, FUNC3_ADD));
    send_instr(enc_imm(5'd2, REG_ZERO, 12'h7FF, FUNC3_ADD));
    send_instr(enc_imm(5'd3, REG_ZERO, 12'h800, FUNC3_ADD));
    send_instr(enc_reg(5'd4, 5'd1, 5'd2, FUNC3_ADD, 7'h00));
    send_instr(enc_reg(5'd5, 5'd1, 5'd3, FUNC3_AND, 7'h00));
    send_instr(enc_reg(5'd6, 5'd4, 5'd1, FUNC3_SLT, 7'h7F));
    send_instr(enc_reg(5'd31, 5'd1, 5'd1, FUNC3_ADD, 7'h20));
    send_instr(enc_imm(REG_ZERO, 5'd1, 12'h005, FUNC3_ADD));
    send_instr(enc_reg(REG_ZERO, 5'd1, 5'd2, FUNC3_ADD, 7'h00));
    send_instr(enc_imm(5'd7, 5'd2, 12'h001, FUNC3_AND));
    send_instr(enc_reg(5'd8, REG_ZERO, REG_ZERO, FUNC3_ADD, 7'h00));
    send_instr(enc_reg(5'd10, 5'd1, REG_ZERO, FUNC3_OR, 7'h00));
    // Doubling chain on x9 runs back-to-back dependent items.
    send_instr(enc_imm(5'd9, REG_ZERO, 12'h001, FUNC3_ADD));
    repeat (3) send_instr(enc_reg(5'd9, 5'd9, 5'd9, FUNC3_ADD, 7'h00));
    send_instr(enc_reg(5'd31, 5'd31, 5'd31, FUNC3_ADD, 7'h00));
    send_instr(enc_imm(5'd31, 5'd31, 12'hFFF, FUNC3_OR));
  endtask

  // Words outside the executed subset leave the registers unchanged.
  task automatic test_unknown_opcodes();
    send_instr('0);
    send_instr('1);
    send_instr({20'hABCDE, 5'd1, OPC_LUI});
    send_instr({25'h1FFFFFF, OPC_BRANCH});
    send_instr({25'h0000F80, 7'h00});
    send_instr(enc_reg(5'd2, 5'd1, 5'd1, FUNC3_ADD, 7'h00) ^ 32'h0000_0001);
  endtask

  task automatic test_random_mix(int count, int idle, int stall);
    src_idle_pct = idle;
    stall_pct <= stall;
    repeat (count) send_instr(rand_instr());
  endtask

  // The receiver holds off while the sender keeps offering items.
  task automatic test_backpressure();
    src_idle_pct = 0;
    stall_pct <= 0;
    fork
      begin
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_hold <= 1'b0;
      end
      repeat (120) send_instr(rand_instr());
    join
  endtask

  // Compares each accepted result with the oldest expectation and draws the next stall.
  always @(posedge clk) begin : result_check
    exec_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result rd=%0d value=%h wrote=%b unknown=%b", $time,
                   dest_index, dest_value, wrote, unknown_op);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          checked++;
          if (dest_index !== want.rd || dest_value !== want.value || wrote !== want.wrote ||
              unknown_op !== want.unknown) begin
            $display("%0t: mismatch expected rd=%0d value=%h wrote=%b unknown=%b", $time,
                     want.rd, want.value, want.wrote, want.unknown);
            $display("%0t:          actual   rd=%0d value=%h wrote=%b unknown=%b", $time,
                     dest_index, dest_value, wrote, unknown_op);
            mismatches++;
          end
        end
      end
      out_stall <= out_hold || ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_arith_edges();
    test_unknown_opcodes();
    test_random_mix(400, 0, 0);
    test_random_mix(400, 50, 0);
    test_random_mix(400, 0, 50);
    test_random_mix(400, 37, 37);
    test_backpressure();
    test_random_mix(80, 0, 0);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Executed %0d register, %0d immediate and %0d unknown-opcode items.",
             n_reg_ops, n_imm_ops, n_unknown);
    $display("Checked %0d results under idle, stall and long hold-off phases; %0d errors.",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
